// ===== rtl/gwk_pkg.sv =====
// Shared types, constants and the sequencer microcode for the graph walker.
package gwk_pkg;

	// Vertex store geometry, fixed by the 3-bit vertex fields
	localparam int MaxVertices = 8;
	localparam int VIdxW       = $clog2(MaxVertices);
	localparam int LvlW        = $clog2(MaxVertices + 1);
	localparam int CntW        = 4;
	localparam int ValW        = 16;
	localparam int DefMaxEdges = 32;

	// Sequencer step counter
	localparam int StepW = 4;

	// Command codes
	typedef enum logic [2:0] {
		CMD_SET   = 3'd0,
		CMD_ADD   = 3'd1,
		CMD_CLEAR = 3'd2,
		CMD_DFS   = 3'd3,
		CMD_BFS   = 3'd4
	} cmd_code_t;

	// Input transaction
	typedef struct packed {
		logic [2:0]             command;
		logic [VIdxW-1:0]       vertex_index;
		logic signed [ValW-1:0] vertex_value;
		logic [VIdxW-1:0]       arc_target;
	} walk_cmd_t;

	// Output transaction
	typedef struct packed {
		logic [VIdxW-1:0]       visit_index;
		logic signed [ValW-1:0] visit_value;
		logic                   last_visit;
		logic                   error;
	} visit_t;

	// Datapath micro-operations
	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_ACCEPT,
		UOP_EXEC,
		UOP_INIT,
		UOP_LOAD_TOP,
		UOP_ARC_LOAD,
		UOP_VISIT,
		UOP_POP,
		UOP_DEQUEUE,
		UOP_FLUSH,
		UOP_ERROR
	} uop_t;

	// Jump conditions
	typedef enum logic [3:0] {
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_BAD_ITEM,
		COND_NOT_WALK,
		COND_IS_BFS,
		COND_LVL_ZERO,
		COND_ARC_NULL,
		COND_STALE,
		COND_QUEUE_EMPTY
	} cond_t;

	// Status flags from the datapath to the sequencer
	typedef struct packed {
		logic no_input;
		logic bad_item;
		logic not_walk;
		logic is_bfs;
		logic lvl_zero;
		logic arc_null;
		logic stale;
		logic queue_empty;
	} cond_flags_t;

	// One control word: operation, jump condition, jump target
	typedef struct packed {
		uop_t             op;
		cond_t            cond;
		logic [StepW-1:0] target;
	} ctrl_word_t;

	// Step labels
	localparam logic [StepW-1:0] StIdle     = 4'd0;
	localparam logic [StepW-1:0] StCheck    = 4'd1;
	localparam logic [StepW-1:0] StExec     = 4'd2;
	localparam logic [StepW-1:0] StInit     = 4'd3;
	localparam logic [StepW-1:0] StDfsTop   = 4'd4;
	localparam logic [StepW-1:0] StDfsArc   = 4'd5;
	localparam logic [StepW-1:0] StDfsLoad  = 4'd6;
	localparam logic [StepW-1:0] StDfsVisit = 4'd7;
	localparam logic [StepW-1:0] StDfsPop   = 4'd8;
	localparam logic [StepW-1:0] StBfsDeq   = 4'd9;
	localparam logic [StepW-1:0] StBfsArc   = 4'd10;
	localparam logic [StepW-1:0] StBfsLoad  = 4'd11;
	localparam logic [StepW-1:0] StBfsVisit = 4'd12;
	localparam logic [StepW-1:0] StFinish   = 4'd13;
	localparam logic [StepW-1:0] StError    = 4'd14;

	// Microcode program
	function automatic ctrl_word_t ucode_rom(input logic [StepW-1:0] s);
		ctrl_word_t w;
		unique case (s)
			StIdle:     w = '{op: UOP_ACCEPT,   cond: COND_NO_INPUT,    target: StIdle};
			StCheck:    w = '{op: UOP_NOP,      cond: COND_BAD_ITEM,    target: StError};
			StExec:     w = '{op: UOP_EXEC,     cond: COND_NOT_WALK,    target: StIdle};
			StInit:     w = '{op: UOP_INIT,     cond: COND_IS_BFS,      target: StBfsDeq};
			StDfsTop:   w = '{op: UOP_LOAD_TOP, cond: COND_LVL_ZERO,    target: StFinish};
			StDfsArc:   w = '{op: UOP_NOP,      cond: COND_ARC_NULL,    target: StDfsPop};
			StDfsLoad:  w = '{op: UOP_ARC_LOAD, cond: COND_STALE,       target: StDfsTop};
			StDfsVisit: w = '{op: UOP_VISIT,    cond: COND_ALWAYS,      target: StDfsTop};
			StDfsPop:   w = '{op: UOP_POP,      cond: COND_ALWAYS,      target: StDfsTop};
			StBfsDeq:   w = '{op: UOP_DEQUEUE,  cond: COND_QUEUE_EMPTY, target: StFinish};
			StBfsArc:   w = '{op: UOP_NOP,      cond: COND_ARC_NULL,    target: StBfsDeq};
			StBfsLoad:  w = '{op: UOP_ARC_LOAD, cond: COND_STALE,       target: StBfsArc};
			StBfsVisit: w = '{op: UOP_VISIT,    cond: COND_ALWAYS,      target: StBfsArc};
			StFinish:   w = '{op: UOP_FLUSH,    cond: COND_ALWAYS,      target: StIdle};
			StError:    w = '{op: UOP_ERROR,    cond: COND_ALWAYS,      target: StIdle};
			default:    w = '{op: UOP_NOP,      cond: COND_ALWAYS,      target: StIdle};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/graph_dfs_bfs_walker.sv =====
// Top level of the directed graph walker: stores, datapath and configuration port.
//
// Directed graph walker for up to 8 vertices and MAX_EDGES arcs, run by a small
// microcoded sequencer that takes one step per clock unless a stalled result
// holds it. Set value, add arc, clear arcs and unused codes pass through the
// accept, check and execute steps; a rejected command goes from the check step
// to the error step. A depth-first arc costs a stack-top load, a null test and
// a registered read of the arc RAM with its test; a breadth-first arc costs only
// the last two. Each visit after the start vertex adds a visit step. Each vertex
// is also popped off the stack by a stack-top load, a null test and a pop step
// (depth-first), or dequeued and its list ended by a dequeue and a null test
// (breadth-first). A step that produces a result waits while the result
// register is stalled.
// Results of a walk come out one per visit, the last one flagged; a bad index or
// a full arc store gives a single result flagged as error and last. The block
// takes no new command until the previous one has finished. vertex_count is at
// byte address 0 of the register port and resets to 8.
module graph_dfs_bfs_walker import gwk_pkg::*; #(
	parameter int MAX_EDGES = DefMaxEdges
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  walk_cmd_t   cmd,
	output logic        visit_valid,
	input  logic        visit_stall,
	output visit_t      visit,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int EW = $clog2(MAX_EDGES + 1);
	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int RW = VIdxW + EW;
	localparam logic [EW-1:0] NullArc = EW'(MAX_EDGES);

	// Control state
	logic [CntW-1:0]        vcount_q;
	logic signed [ValW-1:0] values_q [MaxVertices];
	logic [EW-1:0]          heads_q [MaxVertices];
	logic [EW-1:0]          used_q;
	logic [MaxVertices-1:0] visited_q;
	logic [LvlW-1:0]        lvl_q;
	logic [LvlW-1:0]        head_q;
	logic                   visit_valid_q;

	// Payload state
	walk_cmd_t              cmd_q;
	logic [EW-1:0]          cur_arc_q;
	logic [VIdxW-1:0]       nxt_v_q;
	logic [EW-1:0]          stack_q [MaxVertices];
	logic [VIdxW-1:0]       queue_q [MaxVertices];
	logic [VIdxW-1:0]       hold_idx_q;
	logic signed [ValW-1:0] hold_val_q;
	visit_t                 visit_q;

	// Sequencer interface
	ctrl_word_t       word;
	logic [StepW-1:0] step;
	cond_flags_t      flags;
	logic             hold;
	logic             emits;
	logic             out_free;
	logic             accept;
	logic             cfg_wr;

	// Datapath signals
	logic [CntW-1:0]        live_cnt;
	logic                   vi_bad;
	logic                   tgt_bad;
	logic                   bad_item;
	logic [VIdxW-1:0]       vaddr;
	logic signed [ValW-1:0] vread;
	logic [VIdxW-1:0]       haddr;
	logic [EW-1:0]          heads_rd;
	logic [LvlW-1:0]        lvl_dec;
	logic                   ram_we;
	logic [RW-1:0]          ram_wdata;
	logic [RW-1:0]          ram_rdata;
	logic [VIdxW-1:0]       rd_tgt;
	logic [EW-1:0]          rd_link;
	logic                   fresh;

	gwk_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.hold   (hold),
		.word   (word),
		.step   (step)
	);

	gwk_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_EDGES)
	) u_arc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (used_q[AW-1:0]),
		.wdata (ram_wdata),
		.raddr (cur_arc_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Handshakes
	assign cmd_stall   = (step != StIdle);
	assign accept      = cmd_valid && !cmd_stall;
	assign visit_valid = visit_valid_q;
	assign visit       = visit_q;
	assign out_free    = !visit_valid_q || !visit_stall;
	assign emits       = (word.op == UOP_VISIT) || (word.op == UOP_FLUSH) ||
	                     (word.op == UOP_ERROR);
	assign hold        = emits && !out_free;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[2] ? 32'd0 : 32'(vcount_q);

	// Clamp the vertex count and check the command
	assign live_cnt = (vcount_q > CntW'(MaxVertices)) ? CntW'(MaxVertices) : vcount_q;
	assign vi_bad   = {1'b0, cmd_q.vertex_index} >= live_cnt;
	assign tgt_bad  = {1'b0, cmd_q.arc_target} >= live_cnt;

	always_comb begin
		unique case (cmd_q.command)
			CMD_SET, CMD_DFS, CMD_BFS: bad_item = vi_bad;
			CMD_ADD:                   bad_item = vi_bad || tgt_bad || (used_q == NullArc);
			default:                   bad_item = 1'b0;
		endcase
	end

	// One read port each on the vertex values and the list heads
	assign vaddr = (word.op == UOP_INIT) ? cmd_q.vertex_index : nxt_v_q;
	assign vread = values_q[vaddr];

	always_comb begin
		unique case (word.op)
			UOP_VISIT:   haddr = nxt_v_q;
			UOP_DEQUEUE: haddr = queue_q[head_q[VIdxW-1:0]];
			default:     haddr = cmd_q.vertex_index;
		endcase
	end
	assign heads_rd = heads_q[haddr];

	// Arc RAM fields and the usable-neighbor test
	assign ram_we    = !hold && (word.op == UOP_EXEC) && (cmd_q.command == CMD_ADD);
	assign ram_wdata = {cmd_q.arc_target, heads_rd};
	assign rd_tgt    = ram_rdata[RW-1:EW];
	assign rd_link   = ram_rdata[EW-1:0];
	assign fresh     = ({1'b0, rd_tgt} < live_cnt) && !visited_q[rd_tgt] &&
	                   (lvl_q < LvlW'(MaxVertices));
	assign lvl_dec   = lvl_q - 1'b1;

	// Flags for the sequencer
	always_comb begin
		flags.no_input    = !cmd_valid;
		flags.bad_item    = bad_item;
		flags.not_walk    = (cmd_q.command != CMD_DFS) && (cmd_q.command != CMD_BFS);
		flags.is_bfs      = (cmd_q.command == CMD_BFS);
		flags.lvl_zero    = (lvl_q == '0);
		flags.arc_null    = (cur_arc_q == NullArc);
		flags.stale       = !fresh;
		flags.queue_empty = (head_q == lvl_q);
	end

	// Update control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q      <= CntW'(MaxVertices);
			used_q        <= '0;
			visited_q     <= '0;
			lvl_q         <= '0;
			head_q        <= '0;
			visit_valid_q <= 1'b0;
			for (int i = 0; i < MaxVertices; i++) begin
				values_q[i] <= '0;
				heads_q[i]  <= NullArc;
			end
		end else begin
			if (cfg_wr && !paddr[2]) begin
				vcount_q <= pwdata[CntW-1:0];
			end
			if (emits && !hold) begin
				visit_valid_q <= 1'b1;
			end else if (!visit_stall) begin
				visit_valid_q <= 1'b0;
			end
			if (!hold) begin
				unique case (word.op)
					UOP_EXEC: begin
						unique case (cmd_q.command)
							CMD_SET: values_q[cmd_q.vertex_index] <= cmd_q.vertex_value;
							CMD_ADD: begin
								heads_q[cmd_q.vertex_index] <= used_q;
								used_q                      <= used_q + 1'b1;
							end
							CMD_CLEAR: begin
								used_q <= '0;
								for (int i = 0; i < MaxVertices; i++) begin
									heads_q[i] <= NullArc;
								end
							end
							default: ;
						endcase
					end
					UOP_INIT: begin
						visited_q <= MaxVertices'(1) << cmd_q.vertex_index;
						lvl_q     <= LvlW'(1);
						head_q    <= '0;
					end
					UOP_VISIT: begin
						visited_q[nxt_v_q] <= 1'b1;
						lvl_q              <= lvl_q + 1'b1;
					end
					UOP_POP: lvl_q <= lvl_dec;
					UOP_DEQUEUE: begin
						if (head_q != lvl_q) begin
							head_q <= head_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Update payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (!hold) begin
			unique case (word.op)
				UOP_INIT: begin
					stack_q[0] <= heads_rd;
					queue_q[0] <= cmd_q.vertex_index;
					hold_idx_q <= cmd_q.vertex_index;
					hold_val_q <= vread;
				end
				UOP_LOAD_TOP: cur_arc_q <= stack_q[lvl_dec[VIdxW-1:0]];
				UOP_ARC_LOAD: begin
					cur_arc_q                     <= rd_link;
					nxt_v_q                       <= rd_tgt;
					stack_q[lvl_dec[VIdxW-1:0]]   <= rd_link;
				end
				UOP_VISIT: begin
					visit_q                     <= '{hold_idx_q, hold_val_q, 1'b0, 1'b0};
					hold_idx_q                  <= nxt_v_q;
					hold_val_q                  <= vread;
					stack_q[lvl_q[VIdxW-1:0]]   <= heads_rd;
					queue_q[lvl_q[VIdxW-1:0]]   <= nxt_v_q;
				end
				UOP_DEQUEUE: cur_arc_q <= heads_rd;
				UOP_FLUSH:   visit_q   <= '{hold_idx_q, hold_val_q, 1'b1, 1'b0};
				UOP_ERROR:   visit_q   <= '{'0, '0, 1'b1, 1'b1};
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		visit_valid && visit.error |-> visit.last_visit)
		else $error("error result without last flag");

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (step == StCheck))
		else $error("accepted command did not enter the check step");

	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= lvl_q) && (lvl_q <= LvlW'(MaxVertices)))
		else $error("walk stack or queue pointer out of bounds");

	a_arcs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= NullArc)
		else $error("arc fill count beyond the arc store");
`endif

endmodule

// ===== rtl/gwk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gwk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/gwk_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
module gwk_seq import gwk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cond_flags_t      flags,
	input  logic             hold,
	output ctrl_word_t       word,
	output logic [StepW-1:0] step
);

	logic [StepW-1:0] step_q;
	logic             taken;

	// Fetch the control word of the current step
	assign word = ucode_rom(step_q);
	assign step = step_q;

	// Evaluate the jump condition
	always_comb begin
		unique case (word.cond)
			COND_ALWAYS:      taken = 1'b1;
			COND_NO_INPUT:    taken = flags.no_input;
			COND_BAD_ITEM:    taken = flags.bad_item;
			COND_NOT_WALK:    taken = flags.not_walk;
			COND_IS_BFS:      taken = flags.is_bfs;
			COND_LVL_ZERO:    taken = flags.lvl_zero;
			COND_ARC_NULL:    taken = flags.arc_null;
			COND_STALE:       taken = flags.stale;
			COND_QUEUE_EMPTY: taken = flags.queue_empty;
			default:          taken = 1'b1;
		endcase
	end

	// Hold, jump or advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= StIdle;
		end else if (!hold) begin
			step_q <= taken ? word.target : step_q + 1'b1;
		end
	end

endmodule

// ===== bench/graph_dfs_bfs_walker_checker.sv =====
// Channel monitor, walk predictor and result scoreboard for the graph walker.
`timescale 1ns / 1ps

module graph_dfs_bfs_walker_checker import gwk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_stall,
	input  walk_cmd_t   cmd,
	input  logic        visit_valid,
	input  logic        visit_stall,
	input  visit_t      visit,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          failures,
	output int          pending
);

	localparam int MaxEdges = DefMaxEdges;
	localparam logic [5:0] NullArc = 6'(MaxEdges);
	localparam logic [2:0] AddrVertexCount = 3'd0;
	localparam int ReportLimit = 10;

	// Shadow of the graph store and register
	logic signed [ValW-1:0] vert_val [MaxVertices];
	logic [5:0]             list_head [MaxVertices];
	logic [2:0]             arc_dst [MaxEdges];
	logic [5:0]             arc_next [MaxEdges];
	int unsigned            arc_fill;
	logic [MaxVertices-1:0] seen;
	logic [CntW-1:0]        vcount_reg;

	visit_t expected_visits [$];

	// Queue one visit and mark the vertex as reached
	task automatic mark_visit(input logic [2:0] v);
		visit_t r;
		seen[v] = 1'b1;
		r.visit_index = v;
		r.visit_value = vert_val[v];
		r.last_visit = 1'b0;
		r.error = 1'b0;
		expected_visits.push_back(r);
	endtask

	task automatic push_error_visit();
		visit_t r;
		r = '0;
		r.last_visit = 1'b1;
		r.error = 1'b1;
		expected_visits.push_back(r);
	endtask

	// Apply one command to the shadow graph and queue the visits it produces
	task automatic predict_visits(input walk_cmd_t c);
		int unsigned live;
		logic [5:0]  stk [MaxVertices];
		logic [2:0]  fifo [MaxVertices];
		int unsigned depth;
		int unsigned hd;
		int unsigned tl;
		logic [5:0]  a;
		logic [2:0]  j;
		logic [2:0]  v;
		live = (vcount_reg < MaxVertices) ? vcount_reg : MaxVertices;
		case (c.command)
			CMD_SET: begin
				if (c.vertex_index >= live)
					push_error_visit();
				else
					vert_val[c.vertex_index] = c.vertex_value;
			end
			CMD_ADD: begin
				if (c.vertex_index >= live || c.arc_target >= live || arc_fill >= MaxEdges) begin
					push_error_visit();
				end else begin
					arc_dst[arc_fill] = c.arc_target;
					arc_next[arc_fill] = list_head[c.vertex_index];
					list_head[c.vertex_index] = 6'(arc_fill);
					arc_fill++;
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < MaxVertices; i++)
					list_head[i] = NullArc;
				arc_fill = 0;
			end
			CMD_DFS: begin
				if (c.vertex_index >= live) begin
					push_error_visit();
				end else begin
					seen = '0;
					mark_visit(c.vertex_index);
					depth = 1;
					stk[0] = list_head[c.vertex_index];
					while (depth > 0) begin
						a = stk[depth-1];
						if (a >= NullArc) begin
							depth--;
						end else begin
							stk[depth-1] = arc_next[a];
							j = arc_dst[a];
							if (j < live && !seen[j] && depth < MaxVertices) begin
								mark_visit(j);
								stk[depth] = list_head[j];
								depth++;
							end
						end
					end
					expected_visits[expected_visits.size()-1].last_visit = 1'b1;
				end
			end
			CMD_BFS: begin
				if (c.vertex_index >= live) begin
					push_error_visit();
				end else begin
					seen = '0;
					mark_visit(c.vertex_index);
					fifo[0] = c.vertex_index;
					hd = 0;
					tl = 1;
					while (hd < tl) begin
						v = fifo[hd];
						hd++;
						a = list_head[v];
						while (a < NullArc) begin
							j = arc_dst[a];
							if (j < live && !seen[j] && tl < MaxVertices) begin
								mark_visit(j);
								fifo[tl] = j;
								tl++;
							end
							a = arc_next[a];
						end
					end
					expected_visits[expected_visits.size()-1].last_visit = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= ReportLimit)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	// Track config writes, predict on accepted commands, score accepted visits
	always @(posedge clk or negedge arst_n) begin
		visit_t want;
		if (!arst_n) begin
			for (int i = 0; i < MaxVertices; i++) begin
				vert_val[i] = '0;
				list_head[i] = NullArc;
			end
			arc_fill = 0;
			seen = '0;
			vcount_reg = 4'd8;
			expected_visits.delete();
			failures = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == AddrVertexCount)
				vcount_reg = pwdata[CntW-1:0];
			if (cmd_valid && !cmd_stall)
				predict_visits(cmd);
			if (visit_valid && !visit_stall) begin
				if (expected_visits.size() == 0) begin
					note_failure($sformatf("unexpected visit idx=%0d val=%0d last=%0b err=%0b",
						visit.visit_index, visit.visit_value, visit.last_visit, visit.error));
				end else begin
					want = expected_visits.pop_front();
					if (visit.visit_index !== want.visit_index ||
					    visit.visit_value !== want.visit_value ||
					    visit.last_visit !== want.last_visit ||
					    visit.error !== want.error)
						note_failure($sformatf(
							"visit mismatch: exp idx=%0d val=%0d last=%0b err=%0b, got idx=%0d val=%0d last=%0b err=%0b",
							want.visit_index, want.visit_value, want.last_visit, want.error,
							visit.visit_index, visit.visit_value, visit.last_visit, visit.error));
				end
			end
			pending <= expected_visits.size();
		end
	end

endmodule

// ===== bench/graph_dfs_bfs_walker_tb.sv =====
// Stimulus, flow control and verdict for the graph walker testbench.
`timescale 1ns / 1ps

module graph_dfs_bfs_walker_tb;
	import gwk_pkg::*;

	localparam int LimitCycles = 500000;
	localparam int SettleCycles = 12;
	localparam int LongHold = 300;
	localparam int HoldPhase = 3;
	localparam int SetWeight = 20;
	localparam int PhaseCount = 12;
	localparam int CmdBits = $bits(walk_cmd_t);
	localparam logic [2:0] AddrVertexCount = 3'd0;
	localparam logic [2:0] CmdSpare = 3'd5;
	localparam logic [2:0] CmdSpareTop = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	walk_cmd_t   cmd = '0;
	logic        visit_valid;
	logic        visit_stall;
	visit_t      visit;
	logic        rx_stall = 1'b0;
	logic        hold_stall = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          failures;
	int          pending;
	int          cycle_count = 0;
	int          phase_no = -1;
	bit          steady = 1'b0;
	logic [3:0]  cur_count = 4'd8;

	assign visit_stall = rx_stall | hold_stall;

	always #5 clk = ~clk;

	graph_dfs_bfs_walker u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.visit_valid (visit_valid),
		.visit_stall (visit_stall),
		.visit       (visit),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	graph_dfs_bfs_walker_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.visit_valid (visit_valid),
		.visit_stall (visit_stall),
		.visit       (visit),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.failures    (failures),
		.pending     (pending)
	);

	// Abort on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LimitCycles) begin
			$display("FAIL graph_dfs_bfs_walker");
			$finish;
		end
	end

	// Receiver: random stall before each visit transaction
	initial begin
		int unsigned pause;
		forever begin
			pause = steady ? 0 : $urandom_range(0, 9);
			if (pause > 0) begin
				rx_stall <= 1'b1;
				repeat (pause) @(posedge clk);
			end
			rx_stall <= 1'b0;
			do @(posedge clk); while (!(visit_valid && !visit_stall));
		end
	end

	// Hold off the visit channel for a long stretch so the walker backs up
	initial begin
		wait (phase_no == HoldPhase);
		repeat (30) @(posedge clk);
		hold_stall <= 1'b1;
		repeat (LongHold) @(posedge clk);
		hold_stall <= 1'b0;
	end

	function automatic walk_cmd_t mk(input logic [2:0] op, input logic [2:0] idx,
	                                 input logic [15:0] val, input logic [2:0] tgt);
		walk_cmd_t c;
		c.command = op;
		c.vertex_index = idx;
		c.vertex_value = val;
		c.arc_target = tgt;
		return c;
	endfunction

	// Build one random command, mostly with in-range indices
	function automatic walk_cmd_t pick_cmd(input int clear_w, input int add_w);
		walk_cmd_t c;
		int unsigned r;
		int unsigned live;
		live = (cur_count < MaxVertices) ? cur_count : MaxVertices;
		c = walk_cmd_t'(CmdBits'($urandom));
		if ($urandom_range(0, 99) < 10)
			return c;
		if (live > 0 && $urandom_range(0, 9) != 0) begin
			c.vertex_index = 3'($urandom_range(0, live - 1));
			c.arc_target = 3'($urandom_range(0, live - 1));
		end
		if ($urandom_range(0, 9) == 0)
			c.vertex_value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		r = $urandom_range(0, 99);
		if (r < clear_w)
			c.command = CMD_CLEAR;
		else if (r < clear_w + SetWeight)
			c.command = CMD_SET;
		else if (r < clear_w + SetWeight + add_w)
			c.command = CMD_ADD;
		else
			c.command = $urandom_range(0, 1) ? CMD_DFS : CMD_BFS;
		return c;
	endfunction

	// Offer one command transaction after a random gap, hold until taken
	task automatic send_cmd(input walk_cmd_t c);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
	endtask

	// Stop offering, wait for all visits, then let the walker go idle
	task automatic drain_walker();
		cmd_valid <= 1'b0;
		repeat (2) @(posedge clk);
		wait (pending == 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [3:0] n);
		cur_count = n;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrVertexCount;
		pwdata <= {28'd0, n};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		logic [3:0] phase_counts [PhaseCount];
		int         n_items;
		int         clear_w;
		int         add_w;
		phase_counts = '{4'd8, 4'd8, 4'd2, 4'd15, 4'd1, 4'd0,
		                 4'd5, 4'd8, 4'd3, 4'd7, 4'd4, 4'd6};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_vertex_count(4'd8);

		// Directed: value extremes, a small cyclic graph, both walks
		send_cmd(mk(CMD_SET, 3'd0, 16'sh7FFF, 3'd0));
		send_cmd(mk(CMD_SET, 3'd7, 16'sh8000, 3'd0));
		send_cmd(mk(CMD_SET, 3'd3, 16'sh1234, 3'd0));
		send_cmd(mk(CMD_SET, 3'd1, 16'shFFFF, 3'd0));
		send_cmd(mk(CMD_ADD, 3'd0, 16'sh0000, 3'd1));
		send_cmd(mk(CMD_ADD, 3'd0, 16'sh0000, 3'd7));
		send_cmd(mk(CMD_ADD, 3'd1, 16'sh0000, 3'd3));
		send_cmd(mk(CMD_ADD, 3'd3, 16'sh0000, 3'd0));
		send_cmd(mk(CMD_ADD, 3'd7, 16'sh0000, 3'd3));
		send_cmd(mk(CMD_ADD, 3'd7, 16'sh0000, 3'd7));
		send_cmd(mk(CMD_DFS, 3'd0, 16'sh0000, 3'd0));
		send_cmd(mk(CMD_BFS, 3'd0, 16'sh0000, 3'd0));
		send_cmd(mk(CMD_DFS, 3'd7, 16'sh0000, 3'd0));
		send_cmd(mk(CMD_BFS, 3'd5, 16'sh0000, 3'd0));
		drain_walker();

		// Directed: shrink the graph so old arcs go stale, out-of-range indices, spare codes
		write_vertex_count(4'd3);
		send_cmd(mk(CMD_DFS, 3'd0, 16'sh0000, 3'd0));
		send_cmd(mk(CMD_SET, 3'd5, 16'sh5555, 3'd0));
		send_cmd(mk(CMD_ADD, 3'd0, 16'sh0000, 3'd4));
		send_cmd(mk(CMD_BFS, 3'd6, 16'sh0000, 3'd0));
		send_cmd(mk(CmdSpare, 3'd2, 16'shA5A5, 3'd6));
		send_cmd(mk(CmdSpareTop, 3'd7, 16'sh7FFF, 3'd7));
		drain_walker();

		// Directed: empty graph rejects every index
		write_vertex_count(4'd0);
		send_cmd(mk(CMD_DFS, 3'd0, 16'sh0000, 3'd0));
		send_cmd(mk(CMD_CLEAR, 3'd0, 16'sh0000, 3'd0));
		drain_walker();

		// Random phases; phase 1 piles up arcs until the store is full
		for (int p = 0; p < PhaseCount; p++) begin
			write_vertex_count(phase_counts[p]);
			phase_no = p;
			steady = (p == HoldPhase || p == 7);
			n_items = (p == 1) ? 50 : 28;
			clear_w = (p == 1) ? 0 : 3;
			add_w = (p == 1) ? 75 : 30;
			for (int k = 0; k < n_items; k++)
				send_cmd(pick_cmd(clear_w, add_w));
			drain_walker();
		end
		steady = 1'b0;

		repeat (20) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("PASS graph_dfs_bfs_walker");
		else
			$display("FAIL graph_dfs_bfs_walker");
		$finish;
	end

endmodule

// ===== graph_dfs_bfs_walker.f =====
rtl/gwk_pkg.sv
rtl/gwk_ram.sv
rtl/gwk_seq.sv
rtl/graph_dfs_bfs_walker.sv
bench/graph_dfs_bfs_walker_checker.sv
bench/graph_dfs_bfs_walker_tb.sv
